/* hw/rtl/dtct_pkg.sv */
// Shared types and constants for the dirty tile change tracker.
// Depends on nothing; dtct_ctrl, dtct_dp and the top level import it.
`default_nettype none
package dtct_pkg;

   localparam int GRID_BITS  = 7;
   localparam int TILE_BITS  = 2 * GRID_BITS;
   localparam int TILES      = 1 << TILE_BITS;
   localparam int ID_BITS    = 16;
   localparam int OBJECTS    = 1 << ID_BITS;
   localparam logic [ID_BITS-1:0] CHANGED_HEAD = '1;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   // Request kinds.
   localparam logic [2:0] KIND_DIRTY  = 3'd0;
   localparam logic [2:0] KIND_STATIC = 3'd1;
   localparam logic [2:0] KIND_SUBMIT = 3'd2;
   localparam logic [2:0] KIND_RESET  = 3'd3;
   localparam logic [2:0] KIND_QUERY  = 3'd4;
   localparam logic [2:0] KIND_MASK   = 3'd5;

   typedef enum logic [4:0] {
      ST_CLEAR_ALL, ST_IDLE, ST_DECODE, ST_CLEAR_OBJ,
      ST_WALK_START, ST_TILE_RD, ST_TILE_OP, ST_WALK_NEXT, ST_FINISH,
      ST_CHAIN_CHK, ST_CHAIN_RD, ST_CHAIN_USE,
      ST_SUB_RD, ST_SUB_OP, ST_SUB_NEXT,
      ST_OBJ_RD, ST_OBJ_OUT, ST_MASK_RD, ST_MASK_OUT, ST_RESP
   } state_type;

   // One span of tiles along one axis.
   typedef struct packed {
      logic       ok;
      logic       empty;
      logic [9:0] lo;
      logic [6:0] hi;
   } span_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clr_tiles;
      logic clr_obj;
      logic walk_init;
      logic tile_rd;
      logic tile_op;
      logic walk_next;
      logic finish;
      logic chain_rd;
      logic chain_use;
      logic sub_rd;
      logic sub_op;
      logic sub_next;
      logic obj_rd;
      logic obj_out;
      logic mask_rd;
      logic mask_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] kind;
      logic       walk_void;
      logic       touch_chain;
      logic       sub_chain;
      logic       chain_done;
      logic       in_submit;
      logic       last_y;
      logic       last_x;
      logic       sweep_last;
      logic       clear_last;
   } sts_type;

endpackage
`default_nettype wire

/* hw/rtl/dtct_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module dtct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/dtct_ctrl.sv */
// Controller state machine of the dirty tile change tracker.
// Depends on dtct_pkg; drives the datapath through cmd_type, reads sts_type.
`default_nettype none
module dtct_ctrl
   import dtct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_ALL;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_ALL: if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:      if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            case (sts.kind)
               KIND_DIRTY, KIND_STATIC: state_in = ST_WALK_START;
               KIND_SUBMIT:             state_in = ST_SUB_RD;
               KIND_RESET:              state_in = ST_CLEAR_OBJ;
               KIND_QUERY:              state_in = ST_OBJ_RD;
               KIND_MASK:               state_in = ST_MASK_RD;
               default:                 state_in = ST_RESP;
            endcase
         end
         ST_CLEAR_OBJ:  if (sts.clear_last) state_in = ST_RESP;
         ST_WALK_START: state_in = sts.walk_void ? ST_FINISH : ST_TILE_RD;
         ST_TILE_RD:    state_in = ST_TILE_OP;
         ST_TILE_OP:    state_in = sts.touch_chain ? ST_CHAIN_CHK : ST_WALK_NEXT;
         ST_WALK_NEXT:  state_in = (sts.last_x && sts.last_y) ? ST_FINISH : ST_TILE_RD;
         ST_FINISH:     state_in = ST_RESP;
         ST_CHAIN_CHK: begin
            if (!sts.chain_done) begin
               state_in = ST_CHAIN_RD;
            end else if (sts.in_submit) begin
               state_in = ST_SUB_NEXT;
            end else begin
               state_in = ST_WALK_NEXT;
            end
         end
         ST_CHAIN_RD:  state_in = ST_CHAIN_USE;
         ST_CHAIN_USE: state_in = ST_CHAIN_CHK;
         ST_SUB_RD:    state_in = ST_SUB_OP;
         ST_SUB_OP:    state_in = sts.sub_chain ? ST_CHAIN_CHK : ST_SUB_NEXT;
         ST_SUB_NEXT:  state_in = sts.sweep_last ? ST_RESP : ST_SUB_RD;
         ST_OBJ_RD:    state_in = ST_OBJ_OUT;
         ST_OBJ_OUT:   state_in = ST_RESP;
         ST_MASK_RD:   state_in = ST_MASK_OUT;
         ST_MASK_OUT:  state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR_ALL: begin
            cmd.clr_tiles = 1'b1;
            cmd.clr_obj   = 1'b1;
         end
         ST_IDLE:       cmd.load      = start;
         ST_CLEAR_OBJ:  cmd.clr_obj   = 1'b1;
         ST_WALK_START: cmd.walk_init = 1'b1;
         ST_TILE_RD:    cmd.tile_rd   = 1'b1;
         ST_TILE_OP:    cmd.tile_op   = 1'b1;
         ST_WALK_NEXT:  cmd.walk_next = !(sts.last_x && sts.last_y);
         ST_FINISH:     cmd.finish    = 1'b1;
         ST_CHAIN_RD:   cmd.chain_rd  = 1'b1;
         ST_CHAIN_USE:  cmd.chain_use = 1'b1;
         ST_SUB_RD:     cmd.sub_rd    = 1'b1;
         ST_SUB_OP:     cmd.sub_op    = 1'b1;
         ST_SUB_NEXT:   cmd.sub_next  = 1'b1;
         ST_OBJ_RD:     cmd.obj_rd    = 1'b1;
         ST_OBJ_OUT:    cmd.obj_out   = 1'b1;
         ST_MASK_RD:    cmd.mask_rd   = 1'b1;
         ST_MASK_OUT:   cmd.mask_out  = 1'b1;
         default:       cmd = '0;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule
`default_nettype wire

/* hw/rtl/dtct_dp.sv */
// Datapath of the dirty tile change tracker: request registers, walk counters,
// tile, list, object and mask memories. Depends on dtct_pkg and dtct_ram.
`default_nettype none
module dtct_dp
   import dtct_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [17:0] req_rect_x,
   input  wire logic signed [17:0] req_rect_y,
   input  wire logic signed [17:0] req_rect_w,
   input  wire logic signed [17:0] req_rect_h,
   input  wire logic [15:0]        req_query_id,
   input  wire logic [13:0]        req_tile_index,
   output logic signed [16:0]      rsp_assigned_id,
   output logic                    rsp_id_changed,
   output logic                    rsp_tile_dirty
);

   // Tiles covered along one axis, from a Q3.14 position and length.
   function automatic span_type calc_span(logic signed [17:0] pos, logic signed [17:0] len);
      logic signed [18:0] fin;
      logic [18:0]        up;
      logic [11:0]        hi_w;
      span_type           s;
      fin     = {pos[17], pos} + {len[17], len};
      up      = {1'b0, fin[17:0]} + 19'd127;
      hi_w    = up[18:7];
      s.ok    = !fin[18];
      s.lo    = pos[17] ? 10'd0 : pos[16:7];
      s.hi    = (hi_w >= 12'd127) ? 7'd127 : hi_w[6:0];
      s.empty = (s.lo > {3'b000, s.hi});
      return s;
   endfunction

   span_type sx, sy;
   assign sx = calc_span(req_rect_x, req_rect_w);
   assign sy = calc_span(req_rect_y, req_rect_h);

   logic [2:0]         kind_ff;
   logic               static_ff;
   logic               void_ff;
   logic [6:0]         x1_ff, x2_ff, y1_ff, y2_ff, x_ff, y_ff;
   logic [15:0]        idx_ff;
   logic [15:0]        slot_ff;
   logic [7:0]         n_ff;
   logic               any_ff, all_ff;
   logic [15:0]        list_used_ff;
   logic [16:0]        next_obj_ff;
   logic [15:0]        query_ff;
   logic [13:0]        tidx_ff;
   logic signed [16:0] assigned_ff;
   logic               changed_ff, tdirty_ff;

   logic [31:0] tile_rd_data, list_rd_data;
   logic [0:0]  obj_rd_data, mask_rd_data;

   // Fields of the tile word read this cycle.
   logic [7:0]  t_cnt, t_prior, cnt_inc;
   logic [15:0] t_head;
   logic        head_chg, keep, list_full;
   assign t_cnt     = tile_rd_data[31:24];
   assign t_prior   = tile_rd_data[23:16];
   assign t_head    = tile_rd_data[15:0];
   assign head_chg  = (t_head == CHANGED_HEAD);
   assign cnt_inc   = (t_cnt == COUNT_MAX) ? COUNT_MAX : t_cnt + 8'd1;
   assign keep      = (cnt_inc <= t_prior) && (cnt_inc != COUNT_MAX);
   assign list_full = (list_used_ff >= 16'hFFFF);

   // Request capture, walk counters and per-request bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         list_used_ff <= '0;
         next_obj_ff  <= '0;
         n_ff         <= '0;
      end else begin
         if (cmd.load) begin
            kind_ff     <= req_kind;
            static_ff   <= (req_kind == KIND_STATIC) && (next_obj_ff < 17'd65535);
            void_ff     <= !sx.ok || !sy.ok || sx.empty || sy.empty;
            x1_ff       <= sx.lo[6:0];
            x2_ff       <= sx.hi;
            y1_ff       <= sy.lo[6:0];
            y2_ff       <= sy.hi;
            query_ff    <= req_query_id;
            tidx_ff     <= req_tile_index;
            idx_ff      <= '0;
            any_ff      <= 1'b0;
            all_ff      <= 1'b1;
            assigned_ff <= -17'sd1;
            changed_ff  <= 1'b0;
            tdirty_ff   <= 1'b0;
            if (req_kind == KIND_RESET) begin
               list_used_ff <= '0;
               next_obj_ff  <= '0;
            end
         end
         if (cmd.clr_obj || cmd.sub_next) begin
            idx_ff <= idx_ff + 16'd1;
         end
         if (cmd.walk_init) begin
            x_ff <= x1_ff;
            y_ff <= y1_ff;
         end
         if (cmd.walk_next) begin
            if (y_ff == y2_ff) begin
               y_ff <= y1_ff;
               x_ff <= x_ff + 7'd1;
            end else begin
               y_ff <= y_ff + 7'd1;
            end
         end
         // Static tile touch: list entry, or a chain to mark.
         if (cmd.tile_op && static_ff && !head_chg) begin
            if (keep) begin
               all_ff <= 1'b0;
               if (!list_full) begin
                  list_used_ff <= list_used_ff + 16'd1;
               end
            end else begin
               any_ff  <= 1'b1;
               slot_ff <= t_head;
               n_ff    <= cnt_inc - 8'd1;
            end
         end
         if (cmd.tile_op && static_ff && head_chg) begin
            any_ff <= 1'b1;
         end
         if (cmd.sub_op) begin
            slot_ff <= t_head;
            n_ff    <= (t_cnt != t_prior && !head_chg) ? t_cnt : 8'd0;
         end
         if (cmd.chain_use) begin
            slot_ff <= list_rd_data[31:16];
            n_ff    <= n_ff - 8'd1;
         end
         if (cmd.finish && static_ff && !all_ff) begin
            assigned_ff <= $signed(next_obj_ff);
            next_obj_ff <= next_obj_ff + 17'd1;
         end
         if (cmd.obj_out) begin
            changed_ff <= obj_rd_data[0];
         end
         if (cmd.mask_out) begin
            tdirty_ff <= mask_rd_data[0];
         end
      end
   end

   // Tile memory: dirty count, prior count and list head per tile.
   logic [TILE_BITS-1:0] tile_addr;
   logic                 tile_we;
   logic [31:0]          tile_wd;
   logic                 sweep_sel;
   assign sweep_sel = cmd.sub_rd || cmd.sub_op || cmd.clr_tiles;
   assign tile_addr = sweep_sel ? idx_ff[TILE_BITS-1:0] : {y_ff, x_ff};

   always_comb begin
      tile_we = 1'b0;
      tile_wd = '0;
      if (cmd.clr_tiles) begin
         tile_we = 1'b1;
      end else if (cmd.tile_op) begin
         if (!static_ff) begin
            tile_we = 1'b1;
            tile_wd = {cnt_inc, t_prior, CHANGED_HEAD};
         end else if (!head_chg) begin
            tile_we = 1'b1;
            if (keep && !list_full) begin
               tile_wd = {cnt_inc, t_prior, list_used_ff};
            end else begin
               tile_wd = {cnt_inc, t_prior, CHANGED_HEAD};
            end
         end
      end else if (cmd.sub_op) begin
         tile_we = 1'b1;
         tile_wd = {8'd0, t_cnt, 16'd0};
      end
   end

   dtct_ram #(.WIDTH(32), .DEPTH(TILES)) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr (tile_addr),
      .wr_data (tile_wd),
      .rd_addr (tile_addr),
      .rd_data (tile_rd_data)
   );

   // List memory: object id low, next slot high.
   logic list_we;
   assign list_we = cmd.tile_op && static_ff && !head_chg && keep && !list_full;

   dtct_ram #(.WIDTH(32), .DEPTH(OBJECTS)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_used_ff),
      .wr_data ({t_head, next_obj_ff[15:0]}),
      .rd_addr (slot_ff),
      .rd_data (list_rd_data)
   );

   // Object changed bits.
   logic        obj_we;
   logic [15:0] obj_waddr;
   logic [0:0]  obj_wd;
   always_comb begin
      obj_we    = 1'b0;
      obj_waddr = idx_ff;
      obj_wd    = 1'b0;
      if (cmd.clr_obj) begin
         obj_we = 1'b1;
      end else if (cmd.chain_use) begin
         obj_we    = 1'b1;
         obj_waddr = list_rd_data[15:0];
         obj_wd    = 1'b1;
      end else if (cmd.finish && static_ff && !all_ff && any_ff) begin
         obj_we    = 1'b1;
         obj_waddr = next_obj_ff[15:0];
         obj_wd    = 1'b1;
      end
   end

   dtct_ram #(.WIDTH(1), .DEPTH(OBJECTS)) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_we),
      .wr_addr (obj_waddr),
      .wr_data (obj_wd),
      .rd_addr (query_ff),
      .rd_data (obj_rd_data)
   );

   // Tile mask bits, rebuilt by submit.
   logic [0:0] mask_wd;
   assign mask_wd = (t_cnt != t_prior) || head_chg;

   dtct_ram #(.WIDTH(1), .DEPTH(TILES)) u_mask_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_tiles || cmd.sub_op),
      .wr_addr (idx_ff[TILE_BITS-1:0]),
      .wr_data (cmd.clr_tiles ? 1'b0 : mask_wd),
      .rd_addr (tidx_ff),
      .rd_data (mask_rd_data)
   );

   // Status toward the controller.
   always_comb begin
      sts             = '0;
      sts.kind        = kind_ff;
      sts.walk_void   = void_ff;
      sts.touch_chain = static_ff && !head_chg && !keep;
      sts.sub_chain   = (t_cnt != t_prior) && !head_chg;
      sts.chain_done  = (n_ff == 8'd0);
      sts.in_submit   = (kind_ff == KIND_SUBMIT);
      sts.last_y      = (y_ff == y2_ff);
      sts.last_x      = (x_ff == x2_ff);
      sts.sweep_last  = (idx_ff[TILE_BITS-1:0] == {TILE_BITS{1'b1}});
      sts.clear_last  = (idx_ff == 16'hFFFF);
   end

   assign rsp_assigned_id = assigned_ff;
   assign rsp_id_changed  = changed_ff;
   assign rsp_tile_dirty  = tdirty_ff;

endmodule
`default_nettype wire

/* hw/rtl/dirty_tile_change_tracker.sv */
// Top level of the dirty tile change tracker: controller plus datapath.
// Depends on dtct_pkg, dtct_ctrl, dtct_dp and dtct_ram.
//
// A request is taken when start is high and busy is low; exactly one response
// follows, shown for one cycle with rsp_valid high, and the receiver cannot
// stall it. After reset the block runs a clearing pass with busy high. Query
// and mask read do one memory read and then respond; unknown kinds respond
// with no other step. Rectangles read and update each covered tile in turn,
// and walk the id list of a static tile that turns changed. Submit sweeps all
// 16384 tiles plus list walks; reset ids clears all 65536 object bits.
`default_nettype none
module dirty_tile_change_tracker
   import dtct_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [17:0] req_rect_x,
   input  wire logic signed [17:0] req_rect_y,
   input  wire logic signed [17:0] req_rect_w,
   input  wire logic signed [17:0] req_rect_h,
   input  wire logic [15:0]        req_query_id,
   input  wire logic [13:0]        req_tile_index,
   output logic                    rsp_valid,
   output logic signed [16:0]      rsp_assigned_id,
   output logic                    rsp_id_changed,
   output logic                    rsp_tile_dirty
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   dtct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Storage and arithmetic.
   dtct_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_query_id    (req_query_id),
      .req_tile_index  (req_tile_index),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_id_changed  (rsp_id_changed),
      .rsp_tile_dirty  (rsp_tile_dirty)
   );

endmodule
`default_nettype wire
